/* design/zip_header_xor_deobfuscator_unit_macros.svh */
// assertion macros for the archive header de-obfuscator
`ifndef ZIP_HEADER_XOR_DEOBFUSCATOR_UNIT_MACROS_SVH
`define ZIP_HEADER_XOR_DEOBFUSCATOR_UNIT_MACROS_SVH

// consequent must hold in the same cycle as the antecedent
`define ZXD_CHECK_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// consequent must hold in the cycle after the antecedent
`define ZXD_CHECK_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* design/zxd_pkg.sv */
// shared types and constants of the archive header de-obfuscator
package zxd_pkg;

    localparam logic [31:0] LOCAL_SIG      = 32'h8badf00d;
    localparam logic [31:0] CENTRAL_SIG    = 32'hf00d8bad;
    localparam logic [31:0] REAL_LOCAL     = 32'h04034b50;
    localparam logic [31:0] REAL_CENTRAL   = 32'h02014b50;
    localparam logic [15:0] KEY16          = 16'hc242;
    localparam logic [31:0] KEY32          = 32'h01174750;
    localparam logic [7:0]  NAME_KEY       = 8'hcd;
    localparam logic [5:0]  LOCAL_HDR_END  = 6'h1e;
    localparam logic [5:0]  CENTRAL_HDR_END = 6'h2e;
    localparam logic [5:0]  HDR_START      = 6'h04;

    // one run: the words caused by one input byte
    typedef struct packed {
        logic [3:0][7:0] bytes;
        logic [1:0]      last_idx;
        logic            fin;
        logic            err;
    } run_t;

endpackage

/* design/zxd_queue.sv */
// short run queue between the classifier and the serializer
module zxd_queue #(
    parameter int DEPTH = 4
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  zxd_pkg::run_t push_run,
    output logic          full,
    input  logic          pop,
    output logic          empty,
    output zxd_pkg::run_t head_run
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    zxd_pkg::run_t entry_reg [DEPTH];
    logic [AW-1:0] wr_ptr_reg;
    logic [AW-1:0] wr_ptr_next;
    logic [AW-1:0] rd_ptr_reg;
    logic [AW-1:0] rd_ptr_next;
    logic [CW-1:0] count_reg;
    logic [CW-1:0] count_next;
    logic          do_push;
    logic          do_pop;

    assign full     = (count_reg == CW'(DEPTH));
    assign empty    = (count_reg == '0);
    assign do_push  = push && !full;
    assign do_pop   = pop && !empty;
    assign head_run = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == AW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == AW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= push_run;
        end
    end

endmodule

/* design/zxd_front.sv */
// byte classifier: record state tracking, key xor and run building
module zxd_front (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    output logic          in_stall,
    input  logic [7:0]    in_byte,
    input  logic          in_final,
    input  logic          q_full,
    output logic          push,
    output zxd_pkg::run_t push_run
);

    typedef enum logic [2:0] {
        R_SIG,
        R_HDR,
        R_NAME,
        R_EXTRA,
        R_COMMENT,
        R_DATA
    } region_t;

    typedef struct packed {
        region_t     region;
        logic [31:0] rem;
    } goto_t;

    region_t         region_reg;
    region_t         region_next;
    logic [5:0]      off_reg;
    logic [5:0]      off_next;
    logic [2:0][7:0] hold_reg;
    logic [2:0][7:0] hold_next;
    logic [31:0]     rem_reg;
    logic [31:0]     rem_next;
    logic [15:0]     name_len_reg;
    logic [15:0]     name_len_next;
    logic [15:0]     extra_len_reg;
    logic [15:0]     extra_len_next;
    logic [15:0]     comment_len_reg;
    logic [15:0]     comment_len_next;
    logic [31:0]     data_len_reg;
    logic [31:0]     data_len_next;
    logic            central_reg;
    logic            central_next;
    logic            stopped_reg;
    logic            stopped_next;

    logic            accept;
    logic            has_run;
    zxd_pkg::run_t   run;
    logic [31:0]     sig_word;
    logic [7:0]      dec;
    logic [5:0]      off_inc;
    logic [5:0]      hdr_end;
    logic [31:0]     rem_dec;
    logic [1:0]      dl_sel;
    logic            xr;
    goto_t           g;

    // key byte for a header offset; 32-bit fields use the wide key
    function automatic logic [7:0] key_at(input logic [5:0] off, input logic cen);
        logic       wide;
        logic [1:0] sel;
        wide = 1'b0;
        sel  = off[1:0] - 2'd2;
        if (!cen)
        begin
            wide = (off >= 6'h0e) && (off < 6'h1a);
        end
        else if ((off >= 6'h10) && (off < 6'h1c))
        begin
            // this wide block starts on a four-byte boundary
            wide = 1'b1;
            sel  = off[1:0];
        end
        else
        begin
            wide = (off >= 6'h26) && (off < 6'h2e);
        end
        if (wide)
        begin
            return zxd_pkg::KEY32[sel*8 +: 8];
        end
        return off[0] ? zxd_pkg::KEY16[15:8] : zxd_pkg::KEY16[7:0];
    endfunction

    // first part from start onward with a nonzero length
    function automatic goto_t go_from(input region_t start, input logic [15:0] nl,
                                      input logic [15:0] el, input logic [15:0] cl,
                                      input logic [31:0] dl, input logic cen);
        goto_t r;
        r.region = R_SIG;
        r.rem    = '0;
        if ((start == R_NAME) && (nl != '0))
        begin
            r.region = R_NAME;
            r.rem    = {16'd0, nl};
        end
        else if (((start == R_NAME) || (start == R_EXTRA)) && (el != '0))
        begin
            r.region = R_EXTRA;
            r.rem    = {16'd0, el};
        end
        else if (cen && ((start == R_NAME) || (start == R_EXTRA) || (start == R_COMMENT))
                 && (cl != '0))
        begin
            r.region = R_COMMENT;
            r.rem    = {16'd0, cl};
        end
        else if (!cen && ((start == R_NAME) || (start == R_EXTRA) || (start == R_DATA))
                 && (dl != '0))
        begin
            r.region = R_DATA;
            r.rem    = dl;
        end
        return r;
    endfunction

    assign in_stall = q_full;
    assign accept   = in_valid && !q_full;
    assign push     = accept && has_run;
    assign push_run = run;

    assign sig_word = {in_byte, hold_reg[2], hold_reg[1], hold_reg[0]};
    assign hdr_end  = central_reg ? zxd_pkg::CENTRAL_HDR_END : zxd_pkg::LOCAL_HDR_END;
    assign off_inc  = off_reg + 6'd1;
    assign dec      = in_byte ^ key_at(off_reg, central_reg);
    assign rem_dec  = rem_reg - {31'd0, (rem_reg != '0)};
    // byte lane of the compressed size, whose field starts two bytes into a word
    assign dl_sel   = off_reg[1:0] - 2'd2;
    assign xr       = (region_reg == R_NAME)
                   || (central_reg && ((region_reg == R_EXTRA) || (region_reg == R_COMMENT)));

    always_comb
    begin
        region_next      = region_reg;
        off_next         = off_reg;
        hold_next        = hold_reg;
        rem_next         = rem_reg;
        name_len_next    = name_len_reg;
        extra_len_next   = extra_len_reg;
        comment_len_next = comment_len_reg;
        data_len_next    = data_len_reg;
        central_next     = central_reg;
        stopped_next     = stopped_reg;
        has_run          = 1'b1;
        run              = '0;
        run.fin          = in_final;
        g                = go_from(R_SIG, '0, '0, '0, '0, 1'b0);

        if (stopped_reg)
        begin
            run.bytes[0] = in_byte;
        end
        else
        begin
            case (region_reg)
                R_SIG:
                begin
                    if (off_reg < 6'd3)
                    begin
                        hold_next[off_reg[1:0]] = in_byte;
                        off_next                = off_inc;
                        has_run                 = in_final;
                        // short signature at end of file goes out raw
                        run.bytes               = sig_word;
                        run.bytes[off_reg[1:0]] = in_byte;
                        run.last_idx            = off_reg[1:0];
                    end
                    else
                    begin
                        run.last_idx = 2'd3;
                        if (!central_reg && (sig_word == zxd_pkg::LOCAL_SIG))
                        begin
                            run.bytes   = zxd_pkg::REAL_LOCAL;
                            region_next = R_HDR;
                            off_next    = zxd_pkg::HDR_START;
                        end
                        else if (sig_word == zxd_pkg::CENTRAL_SIG)
                        begin
                            run.bytes    = zxd_pkg::REAL_CENTRAL;
                            central_next = 1'b1;
                            region_next  = R_HDR;
                            off_next     = zxd_pkg::HDR_START;
                        end
                        else
                        begin
                            run.bytes    = sig_word;
                            run.err      = 1'b1;
                            stopped_next = 1'b1;
                        end
                    end
                end
                R_HDR:
                begin
                    run.bytes[0] = dec;
                    // capture length fields from the decoded byte
                    if (!central_reg)
                    begin
                        if ((off_reg >= 6'h12) && (off_reg < 6'h16))
                        begin
                            data_len_next[dl_sel*8 +: 8] = dec;
                        end
                        else if ((off_reg == 6'h1a) || (off_reg == 6'h1b))
                        begin
                            name_len_next[off_reg[0]*8 +: 8] = dec;
                        end
                        else if ((off_reg == 6'h1c) || (off_reg == 6'h1d))
                        begin
                            extra_len_next[off_reg[0]*8 +: 8] = dec;
                        end
                    end
                    else
                    begin
                        if ((off_reg == 6'h1c) || (off_reg == 6'h1d))
                        begin
                            name_len_next[off_reg[0]*8 +: 8] = dec;
                        end
                        else if ((off_reg == 6'h1e) || (off_reg == 6'h1f))
                        begin
                            extra_len_next[off_reg[0]*8 +: 8] = dec;
                        end
                        else if ((off_reg == 6'h20) || (off_reg == 6'h21))
                        begin
                            comment_len_next[off_reg[0]*8 +: 8] = dec;
                        end
                    end
                    if (off_inc >= hdr_end)
                    begin
                        g = go_from(R_NAME, name_len_next, extra_len_next,
                                    comment_len_next, data_len_next, central_reg);
                        region_next = g.region;
                        rem_next    = g.rem;
                        off_next    = '0;
                    end
                    else
                    begin
                        off_next = off_inc;
                    end
                end
                R_NAME, R_EXTRA, R_COMMENT, R_DATA:
                begin
                    run.bytes[0] = xr ? (in_byte ^ zxd_pkg::NAME_KEY) : in_byte;
                    rem_next     = rem_dec;
                    if (rem_dec == '0)
                    begin
                        if (region_reg == R_NAME)
                        begin
                            g = go_from(R_EXTRA, name_len_reg, extra_len_reg,
                                        comment_len_reg, data_len_reg, central_reg);
                        end
                        else if (region_reg == R_EXTRA)
                        begin
                            g = go_from(central_reg ? R_COMMENT : R_DATA, name_len_reg,
                                        extra_len_reg, comment_len_reg, data_len_reg,
                                        central_reg);
                        end
                        region_next = g.region;
                        if (g.region == R_SIG)
                        begin
                            off_next = '0;
                        end
                        else
                        begin
                            rem_next = g.rem;
                        end
                    end
                end
                default:
                begin
                    region_next = R_SIG;
                    off_next    = '0;
                    has_run     = 1'b0;
                end
            endcase
        end

        // end of file: back to reset values for the next file
        if (in_final)
        begin
            region_next      = R_SIG;
            off_next         = '0;
            hold_next        = '0;
            rem_next         = '0;
            name_len_next    = '0;
            extra_len_next   = '0;
            comment_len_next = '0;
            data_len_next    = '0;
            central_next     = 1'b0;
            stopped_next     = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            region_reg      <= R_SIG;
            off_reg         <= '0;
            hold_reg        <= '0;
            rem_reg         <= '0;
            name_len_reg    <= '0;
            extra_len_reg   <= '0;
            comment_len_reg <= '0;
            data_len_reg    <= '0;
            central_reg     <= 1'b0;
            stopped_reg     <= 1'b0;
        end
        else if (accept)
        begin
            region_reg      <= region_next;
            off_reg         <= off_next;
            hold_reg        <= hold_next;
            rem_reg         <= rem_next;
            name_len_reg    <= name_len_next;
            extra_len_reg   <= extra_len_next;
            comment_len_reg <= comment_len_next;
            data_len_reg    <= data_len_next;
            central_reg     <= central_next;
            stopped_reg     <= stopped_next;
        end
    end

endmodule

/* design/zxd_back.sv */
// run serializer: one output word per cycle while out_stall is low, from the queue head
module zxd_back (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          q_empty,
    input  zxd_pkg::run_t head_run,
    output logic          pop,
    output logic          out_valid,
    input  logic          out_stall,
    output logic [7:0]    out_byte,
    output logic          out_run_end,
    output logic          out_file_end,
    output logic          out_sig_error
);

    logic [1:0] idx_reg;
    logic [1:0] idx_next;
    logic       take;

    assign out_valid     = !q_empty;
    assign out_byte      = head_run.bytes[idx_reg];
    assign out_run_end   = (idx_reg == head_run.last_idx);
    assign out_file_end  = out_run_end && head_run.fin;
    assign out_sig_error = head_run.err;
    assign take          = out_valid && !out_stall;
    assign pop           = take && out_run_end;

    always_comb
    begin
        idx_next = idx_reg;
        if (take)
        begin
            idx_next = out_run_end ? 2'd0 : idx_reg + 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg <= '0;
        end
        else
        begin
            idx_reg <= idx_next;
        end
    end

endmodule

/* design/zip_header_xor_deobfuscator_unit.sv */
// with an empty run queue a word is out right after the edge that accepts its byte; behind
//   a signature run it waits while the earlier words drain
// throughput: one byte in per cycle while the queue has room; a four-word signature run is
//   balanced by its three held bytes; QUEUE_DEPTH 5 avoids input stalls unless out_stall holds
// reset: rst_n clears record state, the run queue and the serializer index asynchronously
// a byte with in_final set flushes held bytes and returns the record state to its start
`include "zip_header_xor_deobfuscator_unit_macros.svh"

module zip_header_xor_deobfuscator_unit #(
    parameter int QUEUE_DEPTH = 5
) (
    input  logic       clk,
    input  logic       rst_n,
    // input channel: one raw archive byte per word
    input  logic       in_valid,
    output logic       in_stall,
    input  logic [7:0] in_byte,
    input  logic       in_final,
    // output channel: one restored byte per word
    output logic       out_valid,
    input  logic       out_stall,
    output logic [7:0] out_byte,
    output logic       out_run_end,
    output logic       out_file_end,
    output logic       out_sig_error
);

    // runs travel from the classifier to the serializer through the queue
    zxd_pkg::run_t push_run;
    zxd_pkg::run_t head_run;
    logic          push;
    logic          q_full;
    logic          q_empty;
    logic          pop;

    // front: tracks signature, header and part regions, builds a run per byte
    zxd_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .in_byte  (in_byte),
        .in_final (in_final),
        .q_full   (q_full),
        .push     (push),
        .push_run (push_run)
    );

    // short queue so input and output can stall independently
    zxd_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_run (push_run),
        .full     (q_full),
        .pop      (pop),
        .empty    (q_empty),
        .head_run (head_run)
    );

    // back: hands out the words of the head run one per cycle while out_stall is low
    zxd_back u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .q_empty       (q_empty),
        .head_run      (head_run),
        .pop           (pop),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .out_byte      (out_byte),
        .out_run_end   (out_run_end),
        .out_file_end  (out_file_end),
        .out_sig_error (out_sig_error)
    );

    // a run is only written into a queue with room
    `ZXD_CHECK_NOW(a_no_overflow, clk, rst_n, push, !q_full, "run pushed into full queue")

    // a word marked end of file also closes its run
    `ZXD_CHECK_NOW(a_file_end_closes_run, clk, rst_n, out_valid && out_file_end,
                   out_run_end, "file end word is not the end of its run")

    // the rest of a run follows without a gap
    `ZXD_CHECK_NEXT(a_run_continues, clk, rst_n, out_valid && !out_stall && !out_run_end,
                    out_valid, "run broken before its last word")

    // error flag stays on across the words of a flagged run
    `ZXD_CHECK_NEXT(a_err_whole_run, clk, rst_n,
                    out_valid && !out_stall && !out_run_end && out_sig_error,
                    out_sig_error, "signature error flag dropped inside a run")

endmodule
